>>> rtl/tkpd_pkg.sv
// Package for the three-key short/long press detector.
// Holds field widths, register indexes, item kind codes and the shared structs.
// No dependencies.
package tkpd_pkg;

    localparam int NUM_KEYS_DEFAULT = 3;

    localparam int KIND_W   = 2;
    localparam int KEY_W    = 2;
    localparam int EVT_W    = 3;
    localparam int TICK_W   = 32;
    localparam int THRESH_W = 16;
    localparam int MASK_W   = 3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_MASK = 2'd2;

    localparam logic [THRESH_W-1:0] DEBOUNCE_RESET   = 16'd5;
    localparam logic [THRESH_W-1:0] LONG_PRESS_RESET = 16'd700;
    localparam logic [MASK_W-1:0]   LEVEL_MASK_RESET = 3'd1;

    localparam logic [KIND_W-1:0] KIND_TICK = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EDGE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SCAN = 2'd2;

    localparam logic [EVT_W-1:0] EVT_NONE = 3'd0;

    typedef struct packed {
        logic [THRESH_W-1:0] debounce_ticks;
        logic [THRESH_W-1:0] long_press_ticks;
        logic [MASK_W-1:0]   pressed_level_mask;
    } cfg_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key_id;
        logic              pin_level;
    } item_t;

endpackage

>>> rtl/three_key_short_long_press_detector_top.sv
// Top level of the three-key short/long press detector.
// Instantiates tkpd_cfg, tkpd_in_reg and tkpd_core; depends on tkpd_pkg.
//
// Input channel: in_valid/in_stall with kind, key_id, pin_level. A tick item
// advances the 32-bit time, an edge item updates the press start of its key
// or the pending event, a scan item returns the pending event and clears it.
// Output channel: out_valid/out_stall with event_code, one item per scan.
// Configuration: cfg_we, cfg_index, cfg_data write debounce_ticks,
// long_press_ticks and pressed_level_mask; write only while idle.
// Flow: an item is captured in the input register and updates the state when
// the core takes it; a scan result is loaded into the output register as the
// scan is taken. It takes one item per cycle unless a scan waits behind a
// stalled result; one state-update stage lies between the two registers.
// Reset clears the time, press starts, pending event and both valid flags,
// and loads the register defaults. A stalled output holds its result; ticks
// and edges keep flowing, and only a scan waits behind a stalled result.
module three_key_short_long_press_detector_top
#(
    parameter int NUM_KEYS = tkpd_pkg::NUM_KEYS_DEFAULT
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [tkpd_pkg::KIND_W-1:0]      kind,
    input  logic [tkpd_pkg::KEY_W-1:0]       key_id,
    input  logic                             pin_level,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [tkpd_pkg::EVT_W-1:0]       event_code,
    input  logic                             cfg_we,
    input  logic [tkpd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tkpd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    tkpd_pkg::cfg_t  cfg;
    tkpd_pkg::item_t s1_item;
    logic            s1_valid;
    logic            take;

    tkpd_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tkpd_in_reg u_in_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .key_id    (key_id),
        .pin_level (pin_level),
        .take      (take),
        .s1_valid  (s1_valid),
        .s1_item   (s1_item)
    );

    tkpd_core #(.NUM_KEYS(NUM_KEYS)) u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .s1_valid   (s1_valid),
        .s1_item    (s1_item),
        .take       (take),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .event_code (event_code)
    );

endmodule

>>> rtl/tkpd_cfg.sv
// Configuration registers of the press detector.
// Depends on tkpd_pkg for register indexes, reset values and cfg_t.
module tkpd_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [tkpd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tkpd_pkg::CFG_DATA_W-1:0]  cfg_data,
    output tkpd_pkg::cfg_t                   cfg
);

    tkpd_pkg::cfg_t cfg_reg;
    tkpd_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                tkpd_pkg::REG_DEBOUNCE:
                    cfg_next.debounce_ticks = cfg_data[tkpd_pkg::THRESH_W-1:0];
                tkpd_pkg::REG_LONG_PRESS:
                    cfg_next.long_press_ticks = cfg_data[tkpd_pkg::THRESH_W-1:0];
                tkpd_pkg::REG_LEVEL_MASK:
                    cfg_next.pressed_level_mask = cfg_data[tkpd_pkg::MASK_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks     <= tkpd_pkg::DEBOUNCE_RESET;
            cfg_reg.long_press_ticks   <= tkpd_pkg::LONG_PRESS_RESET;
            cfg_reg.pressed_level_mask <= tkpd_pkg::LEVEL_MASK_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/tkpd_in_reg.sv
// Input register of the detector: captures one item per cycle unless
// the held item is not yet taken. Depends on tkpd_pkg for item_t.
module tkpd_in_reg
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [tkpd_pkg::KIND_W-1:0]  kind,
    input  logic [tkpd_pkg::KEY_W-1:0]   key_id,
    input  logic                         pin_level,
    input  logic                         take,
    output logic                         s1_valid,
    output tkpd_pkg::item_t              s1_item
);

    logic            valid_reg;
    logic            valid_next;
    tkpd_pkg::item_t item_reg;
    tkpd_pkg::item_t item_next;
    logic            load;

    assign in_stall = valid_reg & ~take;
    assign load     = in_valid & ~in_stall;

    always_comb
    begin
        valid_next = in_stall ? valid_reg : in_valid;
        item_next  = item_reg;
        if (load)
        begin
            item_next.kind      = kind;
            item_next.key_id    = key_id;
            item_next.pin_level = pin_level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign s1_valid = valid_reg;
    assign s1_item  = item_reg;

endmodule

>>> rtl/tkpd_core.sv
// State update and result register of the press detector.
// Holds the tick counter, press start times and pending event; depends on tkpd_pkg.
module tkpd_core
#(
    parameter int NUM_KEYS = tkpd_pkg::NUM_KEYS_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  tkpd_pkg::cfg_t              cfg,
    input  logic                        s1_valid,
    input  tkpd_pkg::item_t             s1_item,
    output logic                        take,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [tkpd_pkg::EVT_W-1:0]  event_code
);

    localparam int KEY_IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int KEY_EXT_W = (KEY_IDX_W > tkpd_pkg::KEY_W) ? KEY_IDX_W : tkpd_pkg::KEY_W;

    logic [tkpd_pkg::TICK_W-1:0] tick_reg;
    logic [tkpd_pkg::TICK_W-1:0] tick_next;
    logic [tkpd_pkg::TICK_W-1:0] press_start_reg  [NUM_KEYS];
    logic [tkpd_pkg::TICK_W-1:0] press_start_next [NUM_KEYS];
    logic [tkpd_pkg::EVT_W-1:0]  pending_reg;
    logic [tkpd_pkg::EVT_W-1:0]  pending_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [tkpd_pkg::EVT_W-1:0]  event_code_reg;
    logic [tkpd_pkg::EVT_W-1:0]  event_code_next;

    logic                        is_scan;
    logic [KEY_EXT_W-1:0]        key_ext;
    logic [KEY_IDX_W-1:0]        key_idx;
    logic                        key_in_range;
    logic [tkpd_pkg::MASK_W:0]   mask_ext;
    logic                        active_high;
    logic                        pressed;
    logic [tkpd_pkg::TICK_W-1:0] held;
    logic                        held_ge_debounce;
    logic                        held_ge_long;
    logic [tkpd_pkg::EVT_W-1:0]  long_code;
    logic [tkpd_pkg::EVT_W-1:0]  short_code;

    assign is_scan = (s1_item.kind == tkpd_pkg::KIND_SCAN);
    assign take    = s1_valid & (~is_scan | ~out_valid_reg | ~out_stall);

    assign key_ext      = KEY_EXT_W'(s1_item.key_id);
    assign key_idx      = key_ext[KEY_IDX_W-1:0];
    assign key_in_range = (32'(s1_item.key_id) < 32'(NUM_KEYS));
    assign mask_ext     = {1'b0, cfg.pressed_level_mask};
    assign active_high  = mask_ext[s1_item.key_id];
    assign pressed      = (s1_item.pin_level == active_high);

    assign held             = tick_reg - press_start_reg[key_idx];
    assign held_ge_debounce = (held >= tkpd_pkg::TICK_W'(cfg.debounce_ticks));
    assign held_ge_long     = (held >= tkpd_pkg::TICK_W'(cfg.long_press_ticks));
    assign long_code  = tkpd_pkg::EVT_W'(32'(NUM_KEYS) + 32'd1 + 32'(s1_item.key_id));
    assign short_code = tkpd_pkg::EVT_W'(32'(s1_item.key_id) + 32'd1);

    always_comb
    begin
        tick_next        = tick_reg;
        press_start_next = press_start_reg;
        pending_next     = pending_reg;
        event_code_next  = event_code_reg;
        out_valid_next   = out_valid_reg & out_stall;
        if (take)
        begin
            case (s1_item.kind)
                tkpd_pkg::KIND_TICK:
                begin
                    tick_next = tick_reg + 1'b1;
                end
                tkpd_pkg::KIND_EDGE:
                begin
                    if (key_in_range)
                    begin
                        if (pressed)
                        begin
                            if (held_ge_debounce)
                            begin
                                press_start_next[key_idx] = tick_reg;
                            end
                        end
                        else if (held_ge_long)
                        begin
                            pending_next = long_code;
                        end
                        else if (held_ge_debounce)
                        begin
                            pending_next = short_code;
                        end
                    end
                end
                tkpd_pkg::KIND_SCAN:
                begin
                    out_valid_next  = 1'b1;
                    event_code_next = pending_reg;
                    pending_next    = tkpd_pkg::EVT_NONE;
                end
                default:
                begin
                    tick_next = tick_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg      <= '0;
            pending_reg   <= tkpd_pkg::EVT_NONE;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                press_start_reg[k] <= '0;
            end
        end
        else
        begin
            tick_reg        <= tick_next;
            pending_reg     <= pending_next;
            out_valid_reg   <= out_valid_next;
            press_start_reg <= press_start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        event_code_reg <= event_code_next;
    end

    assign out_valid  = out_valid_reg;
    assign event_code = event_code_reg;

    a_scan_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (take && is_scan) |=> out_valid_reg)
        else $error("scan item did not produce a result");

    a_scan_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (take && is_scan) |=> (pending_reg == tkpd_pkg::EVT_NONE))
        else $error("pending event not cleared by scan");

    a_tick_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (take && s1_item.kind == tkpd_pkg::KIND_TICK)
        |=> (tick_reg == $past(tick_reg) + 1'b1))
        else $error("tick counter did not advance");

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg && !(take && is_scan)) |=> !out_valid_reg)
        else $error("result appeared without a scan");

endmodule

>>> verif/tkpd_press_checker.sv
// Checker for the three-key short/long press detector: watches the item, result
// and register write ports, keeps its own copy of time, press starts and event.
// Depends on tkpd_pkg; reports a failure count and the number of awaited results.
module tkpd_press_checker
#(
    parameter int NUM_KEYS = tkpd_pkg::NUM_KEYS_DEFAULT
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic [tkpd_pkg::KIND_W-1:0]      kind,
    input  logic [tkpd_pkg::KEY_W-1:0]       key_id,
    input  logic                             pin_level,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic [tkpd_pkg::EVT_W-1:0]       event_code,
    input  logic                             cfg_we,
    input  logic [tkpd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tkpd_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               fail_count,
    output int                               pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    bit [tkpd_pkg::TICK_W-1:0]   now_ticks;
    bit [tkpd_pkg::TICK_W-1:0]   press_time [NUM_KEYS];
    bit [tkpd_pkg::EVT_W-1:0]    held_event;
    bit [tkpd_pkg::THRESH_W-1:0] debounce_th;
    bit [tkpd_pkg::THRESH_W-1:0] long_th;
    bit [tkpd_pkg::MASK_W-1:0]   level_mask;
    bit [tkpd_pkg::EVT_W-1:0]    expected_events [$];
    int                          mismatches;

    task automatic apply_edge(input bit [tkpd_pkg::KEY_W-1:0] key, input bit level);
        bit                        active_high;
        bit [tkpd_pkg::TICK_W-1:0] held;
        if (key >= NUM_KEYS)
            return;
        active_high = (key < tkpd_pkg::MASK_W) && level_mask[key];
        held = now_ticks - press_time[key];
        if (level == active_high)
        begin
            if (held >= debounce_th)
                press_time[key] = now_ticks;
        end
        else if (held >= long_th)
            held_event = tkpd_pkg::EVT_W'(NUM_KEYS + 1 + key);
        else if (held >= debounce_th)
            held_event = tkpd_pkg::EVT_W'(key + 1);
    endtask

    task automatic check_event(input logic [tkpd_pkg::EVT_W-1:0] got);
        bit [tkpd_pkg::EVT_W-1:0] want;
        if (expected_events.size() == 0)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("event_code %0d arrived with no scan outstanding", got);
        end
        else
        begin
            want = expected_events.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("event_code mismatch: expected %0d, got %0d", want, got);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_ticks = '0;
            foreach (press_time[k])
                press_time[k] = '0;
            held_event = tkpd_pkg::EVT_NONE;
            debounce_th = tkpd_pkg::DEBOUNCE_RESET;
            long_th = tkpd_pkg::LONG_PRESS_RESET;
            level_mask = tkpd_pkg::LEVEL_MASK_RESET;
            expected_events.delete();
            mismatches = 0;
            fail_count <= 0;
            pending_results <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    tkpd_pkg::REG_DEBOUNCE:   debounce_th = cfg_data;
                    tkpd_pkg::REG_LONG_PRESS: long_th = cfg_data;
                    tkpd_pkg::REG_LEVEL_MASK: level_mask = cfg_data[tkpd_pkg::MASK_W-1:0];
                    default:                  ;
                endcase
            end
            if (out_valid && !out_stall)
                check_event(event_code);
            if (in_valid && !in_stall)
            begin
                case (kind)
                    tkpd_pkg::KIND_TICK: now_ticks = now_ticks + 1;
                    tkpd_pkg::KIND_EDGE: apply_edge(key_id, pin_level);
                    tkpd_pkg::KIND_SCAN:
                    begin
                        expected_events.push_back(held_event);
                        held_event = tkpd_pkg::EVT_NONE;
                    end
                    default:             ;
                endcase
            end
            fail_count <= mismatches;
            pending_results <= expected_events.size();
        end
    end

endmodule

>>> verif/three_key_short_long_press_detector_top_tb.sv
// Testbench top for the three-key short/long press detector: drives ticks, key
// edges, scans and register writes under several idling patterns and gives the
// verdict. Depends on tkpd_pkg, the block and tkpd_press_checker.
module three_key_short_long_press_detector_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int                          KEYS         = tkpd_pkg::NUM_KEYS_DEFAULT;
    localparam logic [tkpd_pkg::KIND_W-1:0] KIND_UNUSED  = 2'd3;
    localparam int                          HOLD_OFF_LEN = 300;
    localparam int                          PHASE_ITEMS  = 195;
    localparam int                          PAUSE_EVERY  = 60;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    logic [tkpd_pkg::KIND_W-1:0]     kind;
    logic [tkpd_pkg::KEY_W-1:0]      key_id;
    logic                            pin_level;
    logic                            out_valid;
    logic                            out_stall;
    logic [tkpd_pkg::EVT_W-1:0]      event_code;
    logic                            cfg_we;
    logic [tkpd_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [tkpd_pkg::CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending_results;
    int hold_requests;
    int send_idle_pct;
    int recv_stall_pct;
    int sent_items;

    bit [tkpd_pkg::THRESH_W-1:0] cur_long;
    bit [tkpd_pkg::MASK_W-1:0]   cur_mask;

    always #5ns clk = ~clk;

    three_key_short_long_press_detector_top u_top
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .key_id     (key_id),
        .pin_level  (pin_level),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .event_code (event_code),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    tkpd_press_checker u_press_check
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .kind            (kind),
        .key_id          (key_id),
        .pin_level       (pin_level),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .event_code      (event_code),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial
    begin
        int hold_left;
        int seen_holds;
        hold_left = 0;
        seen_holds = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != seen_holds)
            begin
                seen_holds = hold_requests;
                hold_left = HOLD_OFF_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    task automatic send_item(input bit [tkpd_pkg::KIND_W-1:0] k,
                             input bit [tkpd_pkg::KEY_W-1:0] id,
                             input bit lvl);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        key_id <= id;
        pin_level <= lvl;
        do
            @(posedge clk);
        while (in_stall);
        if (k != KIND_UNUSED && !(k == tkpd_pkg::KIND_EDGE && id >= KEYS))
            sent_items++;
    endtask

    task automatic send_noise();
        send_item(tkpd_pkg::KIND_W'($urandom_range(0, 3)),
                  tkpd_pkg::KEY_W'($urandom_range(0, 3)),
                  1'($urandom_range(0, 1)));
    endtask

    task automatic send_ticks(input int count);
        repeat (count)
            send_item(tkpd_pkg::KIND_TICK, tkpd_pkg::KEY_W'($urandom_range(0, 3)),
                      1'($urandom_range(0, 1)));
    endtask

    task automatic send_scan();
        send_item(tkpd_pkg::KIND_SCAN, tkpd_pkg::KEY_W'($urandom_range(0, 3)),
                  1'($urandom_range(0, 1)));
    endtask

    task automatic stop_sending();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results != 0);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic write_regs(input bit [tkpd_pkg::THRESH_W-1:0] deb,
                              input bit [tkpd_pkg::THRESH_W-1:0] lng,
                              input bit [tkpd_pkg::MASK_W-1:0] msk);
        cfg_we <= 1'b1;
        cfg_index <= tkpd_pkg::REG_DEBOUNCE;
        cfg_data <= deb;
        @(posedge clk);
        cfg_index <= tkpd_pkg::REG_LONG_PRESS;
        cfg_data <= lng;
        @(posedge clk);
        cfg_index <= tkpd_pkg::REG_LEVEL_MASK;
        cfg_data <= tkpd_pkg::CFG_DATA_W'(msk);
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_long = lng;
        cur_mask = msk;
    endtask

    task automatic press_sequence();
        bit [tkpd_pkg::KEY_W-1:0] id;
        bit                       down;
        int                       hold;
        if ($urandom_range(0, 15) == 0)
            id = tkpd_pkg::KEY_W'(KEYS);
        else
            id = tkpd_pkg::KEY_W'($urandom_range(0, KEYS - 1));
        down = (id < KEYS) ? cur_mask[id] : 1'b0;
        if ($urandom_range(0, 3) == 0)
        begin
            send_item(tkpd_pkg::KIND_EDGE, id, down);
            send_ticks($urandom_range(0, 3));
        end
        send_item(tkpd_pkg::KIND_EDGE, id, down);
        if ($urandom_range(0, 49) == 0 && cur_long <= 1000)
            hold = $urandom_range(cur_long, cur_long + 10);
        else
            hold = $urandom_range(0, 40);
        send_ticks(hold);
        send_item(tkpd_pkg::KIND_EDGE, id, !down);
        if ($urandom_range(0, 9) < 6)
            send_scan();
    endtask

    task automatic run_phase(input int mode, input bit pressure, input bit pauses);
        int start;
        int next_pause;
        case (mode)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 57; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 57; end
            default: begin send_idle_pct = 10; recv_stall_pct = 10; end
        endcase
        start = sent_items;
        next_pause = PAUSE_EVERY;
        if (pressure)
            hold_requests <= hold_requests + 1;
        while (sent_items - start < PHASE_ITEMS)
        begin
            if ($urandom_range(0, 4) == 0)
                send_noise();
            else
                press_sequence();
            if (pauses && sent_items - start >= next_pause)
            begin
                stop_sending();
                next_pause += PAUSE_EVERY;
            end
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        kind <= tkpd_pkg::KIND_TICK;
        key_id <= '0;
        pin_level <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= tkpd_pkg::REG_DEBOUNCE;
        cfg_data <= '0;
        hold_requests <= 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        sent_items = 0;
        cur_long = tkpd_pkg::LONG_PRESS_RESET;
        cur_mask = tkpd_pkg::LEVEL_MASK_RESET;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(tkpd_pkg::KIND_SCAN, 2'd0, 1'b0);
        send_item(KIND_UNUSED, 2'd3, 1'b1);
        send_item(tkpd_pkg::KIND_EDGE, 2'd3, 1'b1);
        send_item(tkpd_pkg::KIND_EDGE, 2'd3, 1'b0);
        send_ticks(6);
        send_item(tkpd_pkg::KIND_EDGE, 2'd0, 1'b1);
        send_ticks(2);
        send_item(tkpd_pkg::KIND_EDGE, 2'd0, 1'b0);
        send_item(tkpd_pkg::KIND_SCAN, 2'd1, 1'b1);
        send_item(tkpd_pkg::KIND_EDGE, 2'd1, 1'b0);
        send_ticks(5);
        send_item(tkpd_pkg::KIND_EDGE, 2'd1, 1'b1);
        send_item(tkpd_pkg::KIND_SCAN, 2'd2, 1'b0);
        send_item(tkpd_pkg::KIND_EDGE, 2'd2, 1'b1);
        send_item(tkpd_pkg::KIND_SCAN, 2'd3, 1'b1);

        stop_sending();
        write_regs('0, '0, 3'b111);
        send_item(tkpd_pkg::KIND_EDGE, 2'd0, 1'b1);
        send_item(tkpd_pkg::KIND_EDGE, 2'd0, 1'b0);
        send_item(tkpd_pkg::KIND_SCAN, 2'd0, 1'b0);
        send_item(tkpd_pkg::KIND_EDGE, 2'd1, 1'b0);
        send_item(tkpd_pkg::KIND_EDGE, 2'd2, 1'b0);
        send_item(tkpd_pkg::KIND_SCAN, 2'd0, 1'b0);
        send_item(tkpd_pkg::KIND_SCAN, 2'd0, 1'b0);

        stop_sending();
        write_regs('1, '1, 3'b000);
        send_item(tkpd_pkg::KIND_EDGE, 2'd0, 1'b0);
        send_ticks(1);
        send_item(tkpd_pkg::KIND_EDGE, 2'd0, 1'b1);
        send_item(tkpd_pkg::KIND_SCAN, 2'd0, 1'b0);

        for (int phase = 0; phase < 8; phase++)
        begin
            stop_sending();
            case (phase)
                0:       write_regs(tkpd_pkg::DEBOUNCE_RESET, tkpd_pkg::LONG_PRESS_RESET,
                                    tkpd_pkg::LEVEL_MASK_RESET);
                1:       write_regs('0, '0, 3'b111);
                2:       write_regs('1, '1, tkpd_pkg::MASK_W'($urandom_range(0, 7)));
                default: write_regs(tkpd_pkg::THRESH_W'($urandom_range(0, 6)),
                                    tkpd_pkg::THRESH_W'($urandom_range(0, 40)),
                                    tkpd_pkg::MASK_W'($urandom_range(0, 7)));
            endcase
            run_phase(phase % 4, phase == 4, phase == 5);
        end

        stop_sending();
        repeat (10)
            @(posedge clk);
        if (fail_count == 0 && pending_results == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("status: fail");
        $finish;
    end

endmodule
